[rtl/core/assert_macros.svh]
// Assertion macros for the RTL that checks its own logic (the top-level core includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define SZE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset
`define SZE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/sze_pkg.sv]
// Shared types, codes, microcode table and constant helpers of the Euler step core.
package sze_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DRIVE_FAST      = 3'd0,
        CFG_DRIVE_SECOND    = 3'd1,
        CFG_THRESHOLD       = 3'd2,
        CFG_TIME_STEP       = 3'd3,
        CFG_NOISE_GAIN      = 3'd4,
        CFG_SLOW_RATE       = 3'd5,
        CFG_MEMORY_DECAY    = 3'd6
    } cfg_t;

    // Shared unit operations
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } op_t;

    // Conditions under which a micro-op runs
    typedef enum logic [2:0] {
        G_ALL   = 3'd0,
        G_X1NEG = 3'd1,
        G_X1POS = 3'd2,
        G_X2HI  = 3'd3,
        G_ZNEG  = 3'd4
    } guard_t;

    // Scratch registers
    localparam int TMP_COUNT    = 17;
    localparam int TMP_IDX_BITS = 5;
    typedef enum logic [TMP_IDX_BITS-1:0] {
        T_N0  = 5'd0,  T_N1  = 5'd1,  T_N2  = 5'd2,  T_N3  = 5'd3,  T_N4 = 5'd4,
        T_G   = 5'd5,  T_SQ  = 5'd6,  T_A   = 5'd7,  T_B   = 5'd8,  T_C  = 5'd9,
        T_D   = 5'd10, T_X1N = 5'd11, T_Y1N = 5'd12, T_X2N = 5'd13,
        T_Y2N = 5'd14, T_ZN  = 5'd15, T_FP  = 5'd16
    } tmp_t;

    // Operand sources; codes with the top bit set read a scratch register
    typedef enum logic [5:0] {
        S_X1    = 6'd0,  S_Y1   = 6'd1,  S_X2    = 6'd2,  S_Y2  = 6'd3,
        S_Z     = 6'd4,  S_GOLD = 6'd5,  S_I1    = 6'd6,  S_I2  = 6'd7,
        S_X0    = 6'd8,  S_H    = 6'd9,  S_GAIN  = 6'd10, S_R   = 6'd11,
        S_DECAY = 6'd12, S_NFP  = 6'd13, S_NFR   = 6'd14, S_NSP = 6'd15,
        S_NSR   = 6'd16, S_NS   = 6'd17,
        K_ONE   = 6'd18, K_3    = 6'd19, K_4     = 6'd20, K_5   = 6'd21,
        K_06    = 6'd22, K_0002 = 6'd23, K_03    = 6'd24, K_35  = 6'd25,
        K_01    = 6'd26, K_025  = 6'd27, K_04    = 6'd28,
        R_N0    = 6'd32, R_N1   = 6'd33, R_N2    = 6'd34, R_N3  = 6'd35,
        R_N4    = 6'd36, R_G    = 6'd37, R_SQ    = 6'd38, R_A   = 6'd39,
        R_B     = 6'd40, R_C    = 6'd41, R_D     = 6'd42, R_X1N = 6'd43,
        R_Y1N   = 6'd44, R_X2N  = 6'd45, R_Y2N   = 6'd46, R_ZN  = 6'd47,
        R_FP    = 6'd48
    } src_t;

    typedef struct packed {
        op_t    op;
        guard_t guard;
        src_t   a;
        src_t   b;
        tmp_t   dst;
    } uop_t;

    localparam int UOP_COUNT = 67;
    localparam int PC_BITS   = 7;
    localparam logic [PC_BITS-1:0] PC_LAST = PC_BITS'(UOP_COUNT - 1);

    // Two's complement of sign and magnitude, clamped to a wbits-wide word
    function automatic logic [63:0] sze_fix(input logic neg, input logic [63:0] mag,
                                            input int wbits);
        logic [63:0] lim;
        logic [63:0] m;
        lim = (64'd1 << (wbits - 1)) - 64'd1;
        m   = mag;
        if (neg)
        begin
            if (m > lim + 64'd1)
                m = lim + 64'd1;
            return ~m + 64'd1;
        end
        if (m > lim)
            m = lim;
        return m;
    endfunction

    function automatic uop_t mk(input op_t o, input guard_t g, input src_t a,
                                input src_t b, input tmp_t d);
        uop_t u;
        u.op    = o;
        u.guard = g;
        u.a     = a;
        u.b     = b;
        u.dst   = d;
        return u;
    endfunction

    // Microcode for one time step
    function automatic uop_t sze_uop(input logic [PC_BITS-1:0] pc);
        uop_t u;
        case (pc)
            // noise terms
            7'd0:  u = mk(OP_MUL, G_ALL,   S_GAIN,  S_NFP,  T_N0);
            7'd1:  u = mk(OP_MUL, G_ALL,   S_GAIN,  S_NFR,  T_N1);
            7'd2:  u = mk(OP_MUL, G_ALL,   S_GAIN,  S_NSP,  T_N2);
            7'd3:  u = mk(OP_MUL, G_ALL,   S_GAIN,  S_NSR,  T_N3);
            7'd4:  u = mk(OP_MUL, G_ALL,   S_GAIN,  S_NS,   T_N4);
            // coupling memory
            7'd5:  u = mk(OP_MUL, G_ALL,   S_DECAY, S_GOLD, T_A);
            7'd6:  u = mk(OP_MUL, G_ALL,   S_H,     S_X1,   T_B);
            7'd7:  u = mk(OP_ADD, G_ALL,   R_A,     R_B,    T_G);
            // first fast variable
            7'd8:  u = mk(OP_MUL, G_ALL,   S_X1,    S_X1,   T_SQ);
            7'd9:  u = mk(OP_SUB, G_ALL,   S_Y1,    S_Z,    T_A);
            7'd10: u = mk(OP_ADD, G_ALL,   R_A,     S_I1,   T_A);
            7'd11: u = mk(OP_MUL, G_ALL,   S_H,     R_A,    T_A);
            7'd12: u = mk(OP_ADD, G_ALL,   S_X1,    R_A,    T_A);
            7'd13: u = mk(OP_ADD, G_ALL,   R_A,     R_N0,   T_X1N);
            7'd14: u = mk(OP_MUL, G_X1NEG, R_SQ,    S_X1,   T_B);
            7'd15: u = mk(OP_MUL, G_X1NEG, K_3,     R_SQ,   T_C);
            7'd16: u = mk(OP_SUB, G_X1NEG, R_B,     R_C,    T_D);
            7'd17: u = mk(OP_SUB, G_X1POS, S_Z,     K_4,    T_B);
            7'd18: u = mk(OP_MUL, G_X1POS, R_B,     R_B,    T_B);
            7'd19: u = mk(OP_MUL, G_X1POS, K_06,    R_B,    T_B);
            7'd20: u = mk(OP_SUB, G_X1POS, S_X2,    R_B,    T_B);
            7'd21: u = mk(OP_MUL, G_X1POS, R_B,     S_X1,   T_D);
            7'd22: u = mk(OP_MUL, G_ALL,   S_H,     R_D,    T_D);
            7'd23: u = mk(OP_SUB, G_ALL,   R_X1N,   R_D,    T_X1N);
            // first recovery variable
            7'd24: u = mk(OP_MUL, G_ALL,   K_5,     R_SQ,   T_A);
            7'd25: u = mk(OP_SUB, G_ALL,   K_ONE,   R_A,    T_A);
            7'd26: u = mk(OP_SUB, G_ALL,   R_A,     S_Y1,   T_A);
            7'd27: u = mk(OP_MUL, G_ALL,   S_H,     R_A,    T_A);
            7'd28: u = mk(OP_ADD, G_ALL,   S_Y1,    R_A,    T_A);
            7'd29: u = mk(OP_ADD, G_ALL,   R_A,     R_N1,   T_Y1N);
            // second fast variable
            7'd30: u = mk(OP_SUB, G_ALL,   S_X2,    S_Y2,   T_A);
            7'd31: u = mk(OP_MUL, G_ALL,   S_X2,    S_X2,   T_B);
            7'd32: u = mk(OP_MUL, G_ALL,   R_B,     S_X2,   T_B);
            7'd33: u = mk(OP_SUB, G_ALL,   R_A,     R_B,    T_A);
            7'd34: u = mk(OP_ADD, G_ALL,   R_A,     S_I2,   T_A);
            7'd35: u = mk(OP_MUL, G_ALL,   K_0002,  R_G,    T_B);
            7'd36: u = mk(OP_ADD, G_ALL,   R_A,     R_B,    T_A);
            7'd37: u = mk(OP_SUB, G_ALL,   S_Z,     K_35,   T_B);
            7'd38: u = mk(OP_MUL, G_ALL,   K_03,    R_B,    T_B);
            7'd39: u = mk(OP_SUB, G_ALL,   R_A,     R_B,    T_A);
            7'd40: u = mk(OP_MUL, G_ALL,   S_H,     R_A,    T_A);
            7'd41: u = mk(OP_ADD, G_ALL,   S_X2,    R_A,    T_A);
            7'd42: u = mk(OP_ADD, G_ALL,   R_A,     R_N2,   T_X2N);
            // second recovery variable
            7'd43: u = mk(OP_MUL, G_ALL,   K_01,    S_Y2,   T_A);
            7'd44: u = mk(OP_MUL, G_ALL,   S_H,     R_A,    T_A);
            7'd45: u = mk(OP_SUB, G_ALL,   S_Y2,    R_A,    T_A);
            7'd46: u = mk(OP_ADD, G_ALL,   R_A,     R_N3,   T_Y2N);
            7'd47: u = mk(OP_ADD, G_X2HI,  S_X2,    K_025,  T_A);
            7'd48: u = mk(OP_MUL, G_X2HI,  K_06,    R_A,    T_A);
            7'd49: u = mk(OP_MUL, G_X2HI,  S_H,     R_A,    T_A);
            7'd50: u = mk(OP_ADD, G_X2HI,  R_Y2N,   R_A,    T_Y2N);
            // slow variable
            7'd51: u = mk(OP_SUB, G_ALL,   S_X1,    S_X0,   T_A);
            7'd52: u = mk(OP_MUL, G_ALL,   K_4,     R_A,    T_A);
            7'd53: u = mk(OP_SUB, G_ALL,   R_A,     S_Z,    T_A);
            7'd54: u = mk(OP_MUL, G_ALL,   S_R,     R_A,    T_A);
            7'd55: u = mk(OP_MUL, G_ALL,   S_H,     R_A,    T_A);
            7'd56: u = mk(OP_ADD, G_ALL,   S_Z,     R_A,    T_A);
            7'd57: u = mk(OP_ADD, G_ALL,   R_A,     R_N4,   T_ZN);
            7'd58: u = mk(OP_MUL, G_ZNEG,  S_Z,     S_Z,    T_B);
            7'd59: u = mk(OP_MUL, G_ZNEG,  R_B,     R_B,    T_C);
            7'd60: u = mk(OP_MUL, G_ZNEG,  R_B,     S_Z,    T_D);
            7'd61: u = mk(OP_MUL, G_ZNEG,  R_C,     R_D,    T_C);
            7'd62: u = mk(OP_MUL, G_ZNEG,  K_04,    R_C,    T_C);
            7'd63: u = mk(OP_MUL, G_ZNEG,  S_R,     R_C,    T_C);
            7'd64: u = mk(OP_MUL, G_ZNEG,  S_H,     R_C,    T_C);
            7'd65: u = mk(OP_SUB, G_ZNEG,  R_ZN,    R_C,    T_ZN);
            // field potential
            7'd66: u = mk(OP_SUB, G_ALL,   R_X2N,   R_X1N,  T_FP);
            default: u = mk(OP_ADD, G_ALL, R_FP, R_FP, T_FP);
        endcase
        return u;
    endfunction

endpackage

[rtl/core/sze_ifs.sv]
// Valid/ready channel interfaces for noise input beats and result beats.
interface sze_in_if #(parameter int IN_BITS = 36);
    logic                      valid;
    logic                      ready;
    logic signed [IN_BITS-1:0] noise_fast_potential;
    logic signed [IN_BITS-1:0] noise_fast_recovery;
    logic signed [IN_BITS-1:0] noise_second_potential;
    logic signed [IN_BITS-1:0] noise_second_recovery;
    logic signed [IN_BITS-1:0] noise_slow;

    modport source (
        output valid, noise_fast_potential, noise_fast_recovery,
               noise_second_potential, noise_second_recovery, noise_slow,
        input  ready
    );
    modport sink (
        input  valid, noise_fast_potential, noise_fast_recovery,
               noise_second_potential, noise_second_recovery, noise_slow,
        output ready
    );
endinterface

interface sze_out_if #(parameter int WORD_BITS = 48);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] fast_potential;
    logic signed [WORD_BITS-1:0] fast_recovery;
    logic signed [WORD_BITS-1:0] second_potential;
    logic signed [WORD_BITS-1:0] second_recovery;
    logic signed [WORD_BITS-1:0] slow_permittivity;
    logic signed [WORD_BITS-1:0] field_potential;
    logic                        saturated;

    modport source (
        output valid, fast_potential, fast_recovery, second_potential,
               second_recovery, slow_permittivity, field_potential, saturated,
        input  ready
    );
    modport sink (
        input  valid, fast_potential, fast_recovery, second_potential,
               second_recovery, slow_permittivity, field_potential, saturated,
        output ready
    );
endinterface

[rtl/core/seizure_model_euler_step_core.sv]
// Top level: sequencer, operand file and state of the seizure-model Euler step.
// One noise beat advances the five model variables and the coupling memory by one
// Euler-Maruyama step and yields one result beat. A small microcode sequencer runs
// 67 micro-ops through one saturating adder and one iterative multiplier; each
// operand is fetched in its own cycle. An add runs through fetch and execute, a
// multiply also waits on the multiplier (four half-width partial products plus
// rounding), and a micro-op whose branch condition is false is skipped; the branches
// taken on x1, x2 and z set the step length. The multiplier is the bottleneck. The
// input is ready only between steps; a finished result waits in the output stage
// while the next beat is already taken. Model state is signed fixed point, with
// FRAC_BITS fraction bits in WORD_BITS; results saturate and set the saturated flag.
module seizure_model_euler_step_core #(
    parameter int WORD_BITS = 48,
    parameter int FRAC_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sze_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]             cfg_data,
    sze_in_if.sink                           noise_in,
    sze_out_if.source                        result_out
);
    import sze_pkg::*;

`include "assert_macros.svh"

    localparam int IN_BITS   = FRAC_BITS + 4;
    localparam int UREG_BITS = FRAC_BITS + 1;

    // fixed-point constants, rounded to nearest and clamped to the word
    localparam logic [WORD_BITS-1:0] V_ONE  = WORD_BITS'(sze_fix(1'b0,
        64'd1 << FRAC_BITS, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_3    = WORD_BITS'(sze_fix(1'b0,
        64'd3 << FRAC_BITS, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_4    = WORD_BITS'(sze_fix(1'b0,
        64'd4 << FRAC_BITS, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_5    = WORD_BITS'(sze_fix(1'b0,
        64'd5 << FRAC_BITS, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_06   = WORD_BITS'(sze_fix(1'b0,
        ((64'd3 << FRAC_BITS) + 64'd2) / 64'd5, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_0002 = WORD_BITS'(sze_fix(1'b0,
        ((64'd1 << FRAC_BITS) + 64'd250) / 64'd500, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_03   = WORD_BITS'(sze_fix(1'b0,
        ((64'd3 << FRAC_BITS) + 64'd5) / 64'd10, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_35   = WORD_BITS'(sze_fix(1'b0,
        ((64'd7 << FRAC_BITS) + 64'd1) / 64'd2, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_01   = WORD_BITS'(sze_fix(1'b0,
        ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_025  = WORD_BITS'(sze_fix(1'b0,
        ((64'd1 << FRAC_BITS) + 64'd2) / 64'd4, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_04   = WORD_BITS'(sze_fix(1'b0,
        ((64'd2 << FRAC_BITS) + 64'd2) / 64'd5, WORD_BITS));
    localparam logic [WORD_BITS-1:0] V_M025 = WORD_BITS'(sze_fix(1'b1,
        ((64'd1 << FRAC_BITS) + 64'd2) / 64'd4, WORD_BITS));

    // register and state reset values
    localparam logic [WORD_BITS-1:0] RST_I1 = WORD_BITS'(sze_fix(1'b0,
        ((64'd31 << FRAC_BITS) + 64'd5) / 64'd10, WORD_BITS));
    localparam logic [WORD_BITS-1:0] RST_I2 = WORD_BITS'(sze_fix(1'b0,
        ((64'd9 << FRAC_BITS) + 64'd10) / 64'd20, WORD_BITS));
    localparam logic [WORD_BITS-1:0] RST_X0 = WORD_BITS'(sze_fix(1'b1,
        ((64'd8 << FRAC_BITS) + 64'd2) / 64'd5, WORD_BITS));
    localparam logic [UREG_BITS-1:0] RST_H = UREG_BITS'(sze_fix(1'b0,
        ((64'd1 << FRAC_BITS) + 64'd128) / 64'd256, WORD_BITS));
    localparam logic [UREG_BITS-1:0] RST_GAIN = UREG_BITS'(sze_fix(1'b0,
        ((64'd1 << FRAC_BITS) + 64'd8) / 64'd16, WORD_BITS));
    localparam logic [UREG_BITS-1:0] RST_R = UREG_BITS'(sze_fix(1'b0,
        ((64'd7 << FRAC_BITS) + 64'd10000) / 64'd20000, WORD_BITS));
    localparam logic [63:0] DECAY_RAW = (FRAC_BITS >= 32)
        ? (64'd4294799527 << (FRAC_BITS - 32))
        : ((64'd4294799527 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
    localparam logic [UREG_BITS-1:0] RST_DECAY = UREG_BITS'(DECAY_RAW);
    localparam logic [WORD_BITS-1:0] RST_X1 = WORD_BITS'(sze_fix(1'b1,
        ((64'd9 << FRAC_BITS) + 64'd2) / 64'd5, WORD_BITS));
    localparam logic [WORD_BITS-1:0] RST_Y1 = WORD_BITS'(sze_fix(1'b1,
        64'd15 << FRAC_BITS, WORD_BITS));
    localparam logic [WORD_BITS-1:0] RST_X2 = WORD_BITS'(sze_fix(1'b1,
        64'd1 << FRAC_BITS, WORD_BITS));
    localparam logic [WORD_BITS-1:0] RST_Z = WORD_BITS'(sze_fix(1'b0,
        64'd3 << FRAC_BITS, WORD_BITS));

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_FETCH_A = 6'b000010,
        ST_FETCH_B = 6'b000100,
        ST_EXEC    = 6'b001000,
        ST_MWAIT   = 6'b010000,
        ST_COMMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [PC_BITS-1:0] pc_reg;

    // configuration registers
    logic [WORD_BITS-1:0] i1_reg, i2_reg, x0_reg;
    logic [UREG_BITS-1:0] h_reg, gain_reg, r_reg, decay_reg;

    // model state
    logic [WORD_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg, z_reg, g_reg;

    // captured noise beat
    logic [IN_BITS-1:0] nfp_reg, nfr_reg, nsp_reg, nsr_reg, ns_reg;

    // scratch, operands, flags, output stage
    logic [WORD_BITS-1:0] tmp_reg [TMP_COUNT];
    logic [WORD_BITS-1:0] opa_reg, opb_reg;
    logic                 clip_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] fp_reg;
    logic                 sat_reg;

    uop_t                 uop;
    src_t                 src_sel;
    logic [WORD_BITS-1:0] src_val;
    logic                 run;
    logic                 in_fire, out_free;
    logic                 mul_start, mul_done, mul_clip;
    logic [WORD_BITS-1:0] mul_y, alu_y;
    logic                 alu_clip;

    assign uop = sze_uop(pc_reg);

    // condition check on the step's starting values
    always_comb
    begin
        case (uop.guard)
            G_ALL:   run = 1'b1;
            G_X1NEG: run = x1_reg[WORD_BITS-1];
            G_X1POS: run = !x1_reg[WORD_BITS-1];
            G_X2HI:  run = $signed(x2_reg) >= $signed(V_M025);
            G_ZNEG:  run = z_reg[WORD_BITS-1];
            default: run = 1'b1;
        endcase
    end

    // operand source select, one read per cycle
    assign src_sel = (state_reg == ST_FETCH_A) ? uop.a : uop.b;

    always_comb
    begin
        if (src_sel[5])
        begin
            src_val = tmp_reg[src_sel[TMP_IDX_BITS-1:0]];
        end
        else
        begin
            case (src_sel)
                S_X1:    src_val = x1_reg;
                S_Y1:    src_val = y1_reg;
                S_X2:    src_val = x2_reg;
                S_Y2:    src_val = y2_reg;
                S_Z:     src_val = z_reg;
                S_GOLD:  src_val = g_reg;
                S_I1:    src_val = i1_reg;
                S_I2:    src_val = i2_reg;
                S_X0:    src_val = x0_reg;
                S_H:     src_val = {{(WORD_BITS-UREG_BITS){1'b0}}, h_reg};
                S_GAIN:  src_val = {{(WORD_BITS-UREG_BITS){1'b0}}, gain_reg};
                S_R:     src_val = {{(WORD_BITS-UREG_BITS){1'b0}}, r_reg};
                S_DECAY: src_val = {{(WORD_BITS-UREG_BITS){1'b0}}, decay_reg};
                S_NFP:   src_val = {{(WORD_BITS-IN_BITS){nfp_reg[IN_BITS-1]}}, nfp_reg};
                S_NFR:   src_val = {{(WORD_BITS-IN_BITS){nfr_reg[IN_BITS-1]}}, nfr_reg};
                S_NSP:   src_val = {{(WORD_BITS-IN_BITS){nsp_reg[IN_BITS-1]}}, nsp_reg};
                S_NSR:   src_val = {{(WORD_BITS-IN_BITS){nsr_reg[IN_BITS-1]}}, nsr_reg};
                S_NS:    src_val = {{(WORD_BITS-IN_BITS){ns_reg[IN_BITS-1]}}, ns_reg};
                K_ONE:   src_val = V_ONE;
                K_3:     src_val = V_3;
                K_4:     src_val = V_4;
                K_5:     src_val = V_5;
                K_06:    src_val = V_06;
                K_0002:  src_val = V_0002;
                K_03:    src_val = V_03;
                K_35:    src_val = V_35;
                K_01:    src_val = V_01;
                K_025:   src_val = V_025;
                K_04:    src_val = V_04;
                default: src_val = '0;
            endcase
        end
    end

    // shared arithmetic units
    sze_addsub #(.WORD_BITS(WORD_BITS)) u_addsub (
        .a    (opa_reg),
        .b    (opb_reg),
        .sub  (uop.op == OP_SUB),
        .y    (alu_y),
        .clip (alu_clip)
    );

    assign mul_start = (state_reg == ST_EXEC) && (uop.op == OP_MUL);

    sze_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa_reg),
        .b     (opb_reg),
        .done  (mul_done),
        .y     (mul_y),
        .clip  (mul_clip)
    );

    assign in_fire  = noise_in.valid && noise_in.ready;
    assign out_free = !out_valid_reg || result_out.ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_FETCH_A;
            end
            ST_FETCH_A:
            begin
                if (run)
                    state_next = ST_FETCH_B;
                else if (pc_reg == PC_LAST)
                    state_next = ST_COMMIT;
            end
            ST_FETCH_B:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (uop.op == OP_MUL)
                    state_next = ST_MWAIT;
                else if (pc_reg == PC_LAST)
                    state_next = ST_COMMIT;
                else
                    state_next = ST_FETCH_A;
            end
            ST_MWAIT:
            begin
                if (mul_done)
                    state_next = (pc_reg == PC_LAST) ? ST_COMMIT : ST_FETCH_A;
            end
            ST_COMMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            i1_reg        <= RST_I1;
            i2_reg        <= RST_I2;
            x0_reg        <= RST_X0;
            h_reg         <= RST_H;
            gain_reg      <= RST_GAIN;
            r_reg         <= RST_R;
            decay_reg     <= RST_DECAY;
            x1_reg        <= RST_X1;
            y1_reg        <= RST_Y1;
            x2_reg        <= RST_X2;
            y2_reg        <= '0;
            z_reg         <= RST_Z;
            g_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DRIVE_FAST:   i1_reg    <= cfg_data;
                    CFG_DRIVE_SECOND: i2_reg    <= cfg_data;
                    CFG_THRESHOLD:    x0_reg    <= cfg_data;
                    CFG_TIME_STEP:    h_reg     <= cfg_data[UREG_BITS-1:0];
                    CFG_NOISE_GAIN:   gain_reg  <= cfg_data[UREG_BITS-1:0];
                    CFG_SLOW_RATE:    r_reg     <= cfg_data[UREG_BITS-1:0];
                    CFG_MEMORY_DECAY: decay_reg <= cfg_data[UREG_BITS-1:0];
                    default: ;
                endcase
            end

            // micro-op counter and step clip flag
            if (in_fire)
            begin
                pc_reg   <= '0;
                clip_reg <= 1'b0;
            end
            else if (state_reg == ST_FETCH_A && !run && pc_reg != PC_LAST)
            begin
                pc_reg <= pc_reg + 1'b1;
            end
            else if (state_reg == ST_EXEC && uop.op != OP_MUL)
            begin
                clip_reg <= clip_reg | alu_clip;
                if (pc_reg != PC_LAST)
                    pc_reg <= pc_reg + 1'b1;
            end
            else if (state_reg == ST_MWAIT && mul_done)
            begin
                clip_reg <= clip_reg | mul_clip;
                if (pc_reg != PC_LAST)
                    pc_reg <= pc_reg + 1'b1;
            end

            // output beat handshake and state commit
            if (state_reg == ST_COMMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                x1_reg        <= tmp_reg[T_X1N];
                y1_reg        <= tmp_reg[T_Y1N];
                x2_reg        <= tmp_reg[T_X2N];
                y2_reg        <= tmp_reg[T_Y2N];
                z_reg         <= tmp_reg[T_ZN];
                g_reg         <= tmp_reg[T_G];
            end
            else if (result_out.valid && result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            nfp_reg <= noise_in.noise_fast_potential;
            nfr_reg <= noise_in.noise_fast_recovery;
            nsp_reg <= noise_in.noise_second_potential;
            nsr_reg <= noise_in.noise_second_recovery;
            ns_reg  <= noise_in.noise_slow;
        end
        if (state_reg == ST_FETCH_A)
            opa_reg <= src_val;
        if (state_reg == ST_FETCH_B)
            opb_reg <= src_val;
        if (state_reg == ST_EXEC && uop.op != OP_MUL)
            tmp_reg[uop.dst] <= alu_y;
        if (state_reg == ST_MWAIT && mul_done)
            tmp_reg[uop.dst] <= mul_y;
        if (state_reg == ST_COMMIT && out_free)
        begin
            fp_reg  <= tmp_reg[T_FP];
            sat_reg <= clip_reg;
        end
    end

    // ports
    assign noise_in.ready               = (state_reg == ST_IDLE);
    assign result_out.valid             = out_valid_reg;
    assign result_out.fast_potential    = x1_reg;
    assign result_out.fast_recovery     = y1_reg;
    assign result_out.second_potential  = x2_reg;
    assign result_out.second_recovery   = y2_reg;
    assign result_out.slow_permittivity = z_reg;
    assign result_out.field_potential   = fp_reg;
    assign result_out.saturated         = sat_reg;

    // checks
    `SZE_ASSERT(a_accept_starts, in_fire |=> state_reg == ST_FETCH_A, "accept did not start a step")
    `SZE_ASSERT(a_mul_done_wait, mul_done |-> state_reg == ST_MWAIT, "multiplier done outside wait")
    `SZE_ASSERT(a_out_from_commit, $rose(result_out.valid) |-> $past(state_reg == ST_COMMIT), "result beat without commit")
    `SZE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !result_out.valid, "result valid during reset")

endmodule

[rtl/core/sze_mul.sv]
// Iterative fixed-point multiplier: four half-width partial products, then round and clip.
module sze_mul #(
    parameter int WORD_BITS = 48,
    parameter int FRAC_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    output logic                 done,
    output logic [WORD_BITS-1:0] y,
    output logic                 clip
);
    localparam int HB = (WORD_BITS + 1) / 2;
    localparam int PW = 4 * HB;

    logic [2*HB-1:0]      ma_reg, mb_reg;
    logic                 neg_reg;
    logic [PW-1:0]        acc_reg;
    logic [1:0]           k_reg;
    logic                 busy_reg, fin_reg, done_reg;
    logic [WORD_BITS-1:0] y_reg;
    logic                 clip_reg;

    logic [WORD_BITS-1:0] a_mag, b_mag;
    logic [HB-1:0]        pa, pb;
    logic [2*HB-1:0]      prod;
    logic [1:0]           sh;
    logic [PW-1:0]        shifted;
    logic [PW-1:0]        rsum, q, bound, mag;
    logic                 over;

    // magnitudes of the operands
    assign a_mag = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    assign b_mag = b[WORD_BITS-1] ? (~b + 1'b1) : b;

    // one partial product per cycle
    always_comb
    begin
        pa   = k_reg[1] ? ma_reg[2*HB-1:HB] : ma_reg[HB-1:0];
        pb   = k_reg[0] ? mb_reg[2*HB-1:HB] : mb_reg[HB-1:0];
        prod = pa * pb;
        sh   = {1'b0, k_reg[1]} + {1'b0, k_reg[0]};
        case (sh)
            2'd0:    shifted = PW'(prod);
            2'd1:    shifted = PW'(prod) << HB;
            default: shifted = PW'(prod) << (2 * HB);
        endcase
    end

    // round to nearest on the magnitude, ties away from zero, then clip
    always_comb
    begin
        rsum  = acc_reg + (PW'(1) << (FRAC_BITS - 1));
        q     = rsum >> FRAC_BITS;
        bound = neg_reg ? (PW'(1) << (WORD_BITS - 1))
                        : ((PW'(1) << (WORD_BITS - 1)) - PW'(1));
        over  = q > bound;
        mag   = over ? bound : q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= 2'd0;
        end
        else
        begin
            // done pulses in the cycle after the rounding stage
            done_reg <= !start && !busy_reg && fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= 2'd0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg <= 1'b0;
            end
        end
    end

    // operand and accumulator datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= (2*HB)'(a_mag);
            mb_reg  <= (2*HB)'(b_mag);
            neg_reg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + shifted;
        end
        if (fin_reg)
        begin
            y_reg    <= neg_reg ? (~mag[WORD_BITS-1:0] + 1'b1) : mag[WORD_BITS-1:0];
            clip_reg <= over;
        end
    end

    assign done = done_reg;
    assign y    = y_reg;
    assign clip = clip_reg;

endmodule

[rtl/core/sze_addsub.sv]
// Saturating add/subtract on signed words with a clip flag.
module sze_addsub #(
    parameter int WORD_BITS = 48
) (
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic                 sub,
    output logic [WORD_BITS-1:0] y,
    output logic                 clip
);
    logic [WORD_BITS:0] ea, eb, s;

    // one extra bit catches overflow; clip toward the true sign
    always_comb
    begin
        ea   = {a[WORD_BITS-1], a};
        eb   = {b[WORD_BITS-1], b};
        s    = sub ? (ea - eb) : (ea + eb);
        clip = s[WORD_BITS] != s[WORD_BITS-1];
        if (!clip)
            y = s[WORD_BITS-1:0];
        else if (s[WORD_BITS])
            y = {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            y = {1'b0, {(WORD_BITS-1){1'b1}}};
    end

endmodule

[verif/seizure_model_euler_step_core_test.sv]
// Self-checking testbench for the seizure-model Euler step core: random noise beats, checked results.
module seizure_model_euler_step_core_test;
    import sze_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = 48;
    localparam int FRAC_BITS = 32;
    localparam int IN_BITS   = 36;
    localparam longint WMAX  = (64'sd1 <<< (WORD_BITS - 1)) - 1;
    localparam longint WMIN  = -WMAX - 1;
    localparam longint UMASK = (64'sd1 <<< (FRAC_BITS + 1)) - 1;
    localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;
    localparam int STEP_CYCLES = 450;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    typedef struct packed {
        logic signed [IN_BITS-1:0] nfp;
        logic signed [IN_BITS-1:0] nfr;
        logic signed [IN_BITS-1:0] nsp;
        logic signed [IN_BITS-1:0] nsr;
        logic signed [IN_BITS-1:0] ns;
    } noise_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] x1;
        logic signed [WORD_BITS-1:0] y1;
        logic signed [WORD_BITS-1:0] x2;
        logic signed [WORD_BITS-1:0] y2;
        logic signed [WORD_BITS-1:0] z;
        logic signed [WORD_BITS-1:0] fp;
        logic                        sat;
    } step_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [WORD_BITS-1:0] cfg_data;

    sze_in_if  #(.IN_BITS(IN_BITS))     noise_bus();
    sze_out_if #(.WORD_BITS(WORD_BITS)) result_bus();

    seizure_model_euler_step_core #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .noise_in(noise_bus), .result_out(result_bus)
    );

    // model state and settings held by the predictor
    longint i1, i2, x0, h, gain, rate, decay;
    longint sx1, sy1, sx2, sy2, sz, sg;
    bit clipped;

    noise_t noise_pending[$];
    step_t  step_expected[$];
    noise_t noise_held;
    int  error_count = 0;
    int  beats_queued = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  saturated_seen = 0;
    bit  quiet = 0;
    longint cycle_count = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint qrat(bit neg, longint num, longint den);
        longint m;
        m = ((num <<< FRAC_BITS) + den / 2) / den;
        return neg ? -m : m;
    endfunction

    function automatic longint sat_word(longint v);
        if (v > WMAX)
        begin
            clipped = 1'b1;
            return WMAX;
        end
        if (v < WMIN)
        begin
            clipped = 1'b1;
            return WMIN;
        end
        return v;
    endfunction

    function automatic longint qadd(longint a, longint b);
        return sat_word(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return sat_word(a - b);
    endfunction

    // product rounded half away from zero on the magnitude, then clamped
    function automatic longint qmul(longint a, longint b);
        bit neg;
        logic [127:0] p;
        logic [127:0] q;
        logic [63:0] ua, ub;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        q = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (neg)
        begin
            if (q > 128'(WMAX) + 128'd1)
            begin
                clipped = 1'b1;
                return WMIN;
            end
            return -longint'(q[63:0]);
        end
        if (q > 128'(WMAX))
        begin
            clipped = 1'b1;
            return WMAX;
        end
        return longint'(q[63:0]);
    endfunction

    function automatic void reset_model();
        i1 = qrat(0, 31, 10);
        i2 = qrat(0, 9, 20);
        x0 = qrat(1, 8, 5);
        h = qrat(0, 1, 256);
        gain = qrat(0, 1, 16);
        rate = qrat(0, 7, 20000);
        decay = 64'd4294799527;
        sx1 = qrat(1, 9, 5);
        sy1 = qrat(1, 15, 1);
        sx2 = qrat(1, 1, 1);
        sy2 = 0;
        sz = qrat(0, 3, 1);
        sg = 0;
    endfunction

    function automatic void apply_setting(cfg_t idx, logic [WORD_BITS-1:0] v);
        longint s, u;
        s = longint'($signed(v));
        u = longint'({16'd0, v}) & UMASK;
        case (idx)
            CFG_DRIVE_FAST:   i1 = s;
            CFG_DRIVE_SECOND: i2 = s;
            CFG_THRESHOLD:    x0 = s;
            CFG_TIME_STEP:    h = u;
            CFG_NOISE_GAIN:   gain = u;
            CFG_SLOW_RATE:    rate = u;
            CFG_MEMORY_DECAY: decay = u;
            default: ;
        endcase
    endfunction

    // one Euler-Maruyama step of the five-variable model
    function automatic step_t advance_model(noise_t nz);
        longint n0, n1, n2, n3, n4, g, sq, t, f, zm4, z2, z7;
        longint x1n, y1n, x2n, y2n, zn;
        step_t r;
        clipped = 1'b0;
        n0 = qmul(gain, longint'(nz.nfp));
        n1 = qmul(gain, longint'(nz.nfr));
        n2 = qmul(gain, longint'(nz.nsp));
        n3 = qmul(gain, longint'(nz.nsr));
        n4 = qmul(gain, longint'(nz.ns));
        g = qadd(qmul(decay, sg), qmul(h, sx1));
        sg = g;
        sq = qmul(sx1, sx1);
        t = qadd(qsub(sy1, sz), i1);
        x1n = qadd(qadd(sx1, qmul(h, t)), n0);
        if (sx1 < 0)
            f = qsub(qmul(sq, sx1), qmul(qrat(0, 3, 1), sq));
        else
        begin
            zm4 = qsub(sz, qrat(0, 4, 1));
            f = qmul(qsub(sx2, qmul(qrat(0, 3, 5), qmul(zm4, zm4))), sx1);
        end
        x1n = qsub(x1n, qmul(h, f));
        t = qsub(qsub(ONE_Q, qmul(qrat(0, 5, 1), sq)), sy1);
        y1n = qadd(qadd(sy1, qmul(h, t)), n1);
        t = qsub(sx2, sy2);
        t = qsub(t, qmul(qmul(sx2, sx2), sx2));
        t = qadd(t, i2);
        t = qadd(t, qmul(qrat(0, 1, 500), g));
        t = qsub(t, qmul(qrat(0, 3, 10), qsub(sz, qrat(0, 7, 2))));
        x2n = qadd(qadd(sx2, qmul(h, t)), n2);
        y2n = qadd(qsub(sy2, qmul(h, qmul(qrat(0, 1, 10), sy2))), n3);
        if (sx2 >= qrat(1, 1, 4))
            y2n = qadd(y2n, qmul(h, qmul(qrat(0, 3, 5), qadd(sx2, qrat(0, 1, 4)))));
        t = qsub(qmul(qrat(0, 4, 1), qsub(sx1, x0)), sz);
        zn = qadd(qadd(sz, qmul(h, qmul(rate, t))), n4);
        if (sz < 0)
        begin
            z2 = qmul(sz, sz);
            z7 = qmul(qmul(z2, z2), qmul(z2, sz));
            zn = qsub(zn, qmul(h, qmul(rate, qmul(qrat(0, 2, 5), z7))));
        end
        r.fp = qsub(x2n, x1n);
        sx1 = x1n;
        sy1 = y1n;
        sx2 = x2n;
        sy2 = y2n;
        sz = zn;
        r.x1 = x1n;
        r.y1 = y1n;
        r.x2 = x2n;
        r.y2 = y2n;
        r.z = zn;
        r.sat = clipped;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_checked, what, got, want);
    endtask

    // source side: presents queued beats, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            noise_bus.valid <= 1'b0;
        else
        begin
            if (noise_bus.valid && noise_bus.ready)
            begin
                step_expected.push_back(advance_model(noise_held));
                beats_sent++;
            end
            if (!noise_bus.valid || noise_bus.ready)
            begin
                if (noise_pending.size() > 0 && (quiet || $urandom_range(99) >= 18))
                begin
                    noise_held = noise_pending.pop_front();
                    noise_bus.valid <= 1'b1;
                    noise_bus.noise_fast_potential <= noise_held.nfp;
                    noise_bus.noise_fast_recovery <= noise_held.nfr;
                    noise_bus.noise_second_potential <= noise_held.nsp;
                    noise_bus.noise_second_recovery <= noise_held.nsr;
                    noise_bus.noise_slow <= noise_held.ns;
                end
                else
                    noise_bus.valid <= 1'b0;
            end
        end
    end

    // sink side: random back-pressure and field-by-field compare
    always @(posedge clk or negedge rst_n)
    begin
        step_t w;
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (step_expected.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 1, 0);
                end
                else
                begin
                    w = step_expected.pop_front();
                    if (result_bus.fast_potential !== w.x1)
                        report_mismatch("fast_potential", result_bus.fast_potential, w.x1);
                    if (result_bus.fast_recovery !== w.y1)
                        report_mismatch("fast_recovery", result_bus.fast_recovery, w.y1);
                    if (result_bus.second_potential !== w.x2)
                        report_mismatch("second_potential", result_bus.second_potential, w.x2);
                    if (result_bus.second_recovery !== w.y2)
                        report_mismatch("second_recovery", result_bus.second_recovery, w.y2);
                    if (result_bus.slow_permittivity !== w.z)
                        report_mismatch("slow_permittivity", result_bus.slow_permittivity, w.z);
                    if (result_bus.field_potential !== w.fp)
                        report_mismatch("field_potential", result_bus.field_potential, w.fp);
                    if (result_bus.saturated !== w.sat)
                        report_mismatch("saturated", result_bus.saturated, w.sat);
                    if (w.sat)
                        saturated_seen++;
                end
                beats_checked++;
            end
            result_bus.ready <= quiet || $urandom_range(99) >= 18;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [IN_BITS-1:0] rand_noise();
        logic [63:0] raw;
        longint v;
        raw = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            return raw[IN_BITS-1:0];
        v = longint'(raw) % (64'sd1 <<< 34);
        return v[IN_BITS-1:0];
    endfunction

    task automatic queue_noise(logic signed [IN_BITS-1:0] a, logic signed [IN_BITS-1:0] b,
                               logic signed [IN_BITS-1:0] c, logic signed [IN_BITS-1:0] d,
                               logic signed [IN_BITS-1:0] e);
        noise_t n;
        n.nfp = a;
        n.nfr = b;
        n.nsp = c;
        n.nsr = d;
        n.ns = e;
        noise_pending.push_back(n);
        beats_queued++;
    endtask

    task automatic write_setting(cfg_t idx, logic [WORD_BITS-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        apply_setting(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // block drained: every queued beat has come back, plus one step of slack
    task automatic drain();
        while (beats_checked < beats_queued)
            @(posedge clk);
        repeat (STEP_CYCLES) @(posedge clk);
    endtask

    function automatic logic [WORD_BITS-1:0] near(longint base, int spread_pct);
        longint d;
        d = (base / 100) * longint'($urandom_range(2 * spread_pct)) - (base / 100) * spread_pct;
        return WORD_BITS'(base + d);
    endfunction

    localparam logic signed [IN_BITS-1:0] NMAX = {1'b0, {(IN_BITS-1){1'b1}}};
    localparam logic signed [IN_BITS-1:0] NMIN = {1'b1, {(IN_BITS-1){1'b0}}};

    initial
    begin
        reset_model();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DRIVE_FAST;
        cfg_data = '0;
        noise_bus.valid = 1'b0;
        noise_bus.noise_fast_potential = '0;
        noise_bus.noise_fast_recovery = '0;
        noise_bus.noise_second_potential = '0;
        noise_bus.noise_second_recovery = '0;
        noise_bus.noise_slow = '0;
        result_bus.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: quiet steps, then noise extremes driving each branch
        queue_noise(0, 0, 0, 0, 0);
        queue_noise(0, 0, 0, 0, 0);
        queue_noise(NMAX, NMAX, NMAX, NMAX, NMAX);
        queue_noise(NMIN, NMIN, NMIN, NMIN, NMIN);
        queue_noise(NMAX, NMIN, NMAX, NMIN, NMIN);
        queue_noise(NMIN, NMAX, NMIN, NMAX, NMIN);
        queue_noise(NMAX, 0, NMAX, 0, NMIN);
        queue_noise(-1, 1, -1, 1, -1);
        drain();

        // extreme settings: unit gains and full-scale drives, then zero gains and opposite drives
        write_setting(CFG_TIME_STEP, 48'h1_0000_0000);
        write_setting(CFG_NOISE_GAIN, 48'h1_0000_0000);
        write_setting(CFG_SLOW_RATE, 48'h1_0000_0000);
        write_setting(CFG_MEMORY_DECAY, 48'h1_0000_0000);
        write_setting(CFG_DRIVE_FAST, WORD_BITS'(WMAX));
        write_setting(CFG_DRIVE_SECOND, WORD_BITS'(WMIN));
        write_setting(CFG_THRESHOLD, WORD_BITS'(WMAX));
        cfg_index <= CFG_IDX_BITS'(7);
        repeat (4) queue_noise(NMAX, NMIN, NMAX, NMIN, NMAX);
        repeat (4) queue_noise(NMIN, NMAX, NMIN, NMAX, NMIN);
        drain();
        // an index past the register list must be ignored
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_BITS'(7);
        cfg_data <= '1;
        @(posedge clk);
        cfg_we <= 1'b0;
        write_setting(CFG_TIME_STEP, 0);
        write_setting(CFG_NOISE_GAIN, 0);
        write_setting(CFG_SLOW_RATE, 0);
        write_setting(CFG_MEMORY_DECAY, 0);
        write_setting(CFG_DRIVE_FAST, WORD_BITS'(WMIN));
        write_setting(CFG_DRIVE_SECOND, WORD_BITS'(WMAX));
        write_setting(CFG_THRESHOLD, WORD_BITS'(WMIN));
        repeat (4) queue_noise(rand_noise(), rand_noise(), rand_noise(), rand_noise(),
                               rand_noise());
        drain();

        // random phases around the nominal operating point
        for (int ph = 0; ph < 12; ph++)
        begin
            int n_items;
            quiet = (ph == 4);
            write_setting(CFG_DRIVE_FAST, near(qrat(0, 31, 10), 40));
            write_setting(CFG_DRIVE_SECOND, near(qrat(0, 9, 20), 40));
            write_setting(CFG_THRESHOLD, near(qrat(1, 8, 5), 40));
            write_setting(CFG_TIME_STEP, (ph % 3 == 0) ? near(qrat(0, 1, 16), 50)
                                                       : near(qrat(0, 1, 256), 50));
            write_setting(CFG_NOISE_GAIN, (ph % 4 == 1) ? near(qrat(0, 1, 2), 50)
                                                        : near(qrat(0, 1, 16), 50));
            write_setting(CFG_SLOW_RATE, (ph % 5 == 2) ? near(qrat(0, 1, 4), 50)
                                                       : near(qrat(0, 7, 20000), 50));
            write_setting(CFG_MEMORY_DECAY, 48'(UMASK >> 1) - $urandom_range(500000));
            n_items = 155;
            for (int k = 0; k < n_items; k++)
                queue_noise(rand_noise(), rand_noise(), rand_noise(), rand_noise(),
                            rand_noise());
            drain();
        end
        quiet = 0;

        $display("Covered %0d noise beats, %0d results checked, %0d with saturation,",
                 beats_sent, beats_checked, saturated_seen);
        $display("over reset, extreme and randomized register settings.");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
